// ===== hdl/bacs_pkg.sv =====
// types and constants shared by the bcd alarm clock files
package bacs_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TIME  = 2'd1,
        MODE_ALARM = 2'd2
    } t_mode;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_J    = 8'h6a;
    localparam logic [7:0] CH_N    = 8'h6e;
    localparam logic [7:0] CH_E    = 8'h65;

    localparam logic [7:0] TICKS_RESET = 8'd20;
    localparam logic [2:0] TIME_POS_MAX  = 3'd6;
    localparam logic [2:0] ALARM_POS_MAX = 3'd4;

    typedef struct packed {
        logic [5:0][3:0] time_dig;
        logic [3:0][3:0] alarm_dig;
        logic [7:0]      tick_count;
        t_mode           mode;
        logic            running;
        logic [2:0]      time_pos;
        logic [2:0]      alarm_pos;
    } t_state;

    typedef struct packed {
        logic [5:0][3:0] time_dig;
        logic            alarm_on;
        logic            format_error;
        logic            time_set_done;
        logic            alarm_set_done;
        logic [1:0]      set_mode;
    } t_result;

    localparam t_state STATE_RESET = '{
        time_dig:   {4'd6, 4'd3, 4'd8, 4'd4, 4'd2, 4'd2},
        alarm_dig:  '0,
        tick_count: 8'd0,
        mode:       MODE_IDLE,
        running:    1'b1,
        time_pos:   3'd0,
        alarm_pos:  3'd0
    };

endpackage

// ===== hdl/bacs_in_if.sv =====
// input channel: tick or received byte
interface bacs_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== hdl/bacs_out_if.sv =====
// result channel: time digits and status flags
interface bacs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
    logic [3:0] second_tens;
    logic [3:0] second_units;
    logic       alarm_on;
    logic       format_error;
    logic       time_set_done;
    logic       alarm_set_done;
    logic [1:0] set_mode;

    modport source (
        output valid, output hour_tens, output hour_units, output minute_tens,
        output minute_units, output second_tens, output second_units,
        output alarm_on, output format_error, output time_set_done,
        output alarm_set_done, output set_mode, input ready
    );
    modport sink (
        input valid, input hour_tens, input hour_units, input minute_tens,
        input minute_units, input second_tens, input second_units,
        input alarm_on, input format_error, input time_set_done,
        input alarm_set_done, input set_mode, output ready
    );
endinterface

// ===== hdl/bacs_cfg_if.sv =====
// configuration write channel for ticks per second
interface bacs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bcd_alarm_clock_serial_set.sv =====
// 24-hour bcd clock with alarm and serial set commands
// an accepted beat is held in the input register, then its result is registered in the output register
// throughput: one beat per cycle while results are read, state updated in one pass of the digit carry chain
// while a result waits unread the input register holds one more beat, then input stalls
// reset (synchronous, active low) loads 22:48:36, alarm 00:00, idle mode, clock running
// and ticks per second of 20; no clearing pass
module bcd_alarm_clock_serial_set
    import bacs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bacs_in_if.sink     i_in,
    bacs_cfg_if.sink    i_cfg,
    bacs_out_if.source  o_out
);

    logic       r_in_vld;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_state     r_state;
    logic [7:0] r_tps;
    t_state     n_state;
    t_result    n_out;
    logic       adv;
    logic       in_take;

    assign adv     = r_in_vld && (!r_out_vld || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_vld || adv;
    assign i_cfg.ready = 1'b1;

    bacs_next u_next (
        .i_state            (r_state),
        .i_operation        (r_in_op),
        .i_rx_byte          (r_in_byte),
        .i_ticks_per_second (r_tps),
        .o_state            (n_state),
        .o_result           (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RESET;
            r_tps     <= TICKS_RESET;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_tps <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.rx_byte;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.hour_tens      = r_out.time_dig[0];
    assign o_out.hour_units     = r_out.time_dig[1];
    assign o_out.minute_tens    = r_out.time_dig[2];
    assign o_out.minute_units   = r_out.time_dig[3];
    assign o_out.second_tens    = r_out.time_dig[4];
    assign o_out.second_units   = r_out.time_dig[5];
    assign o_out.alarm_on       = r_out.alarm_on;
    assign o_out.format_error   = r_out.format_error;
    assign o_out.time_set_done  = r_out.time_set_done;
    assign o_out.alarm_set_done = r_out.alarm_set_done;
    assign o_out.set_mode       = r_out.set_mode;

endmodule

// ===== hdl/bacs_next.sv =====
// next clock state and result for one beat
module bacs_next
    import bacs_pkg::*;
(
    input  t_state     i_state,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_ticks_per_second,
    output t_state     o_state,
    output t_result    o_result
);

    logic [5:0][3:0] tick_dig;
    logic [4:0]      v5, v4, v3, v2, v1;
    logic [8:0]      tick_inc;
    logic            sec_pulse;
    logic            is_digit;
    logic [3:0]      digit_val;
    logic            ferr, tdone, adone;
    logic            alarm;
    t_state          nxt;

    // seconds carry chain
    always_comb begin
        tick_dig = i_state.time_dig;
        v5 = {1'b0, i_state.time_dig[5]} + 5'd1;
        v4 = {1'b0, i_state.time_dig[4]} + 5'd1;
        v3 = {1'b0, i_state.time_dig[3]} + 5'd1;
        v2 = {1'b0, i_state.time_dig[2]} + 5'd1;
        v1 = {1'b0, i_state.time_dig[1]} + 5'd1;
        tick_dig[5] = v5[3:0];
        if (v5 >= 5'd10) begin
            tick_dig[5] = 4'd0;
            tick_dig[4] = v4[3:0];
            if (v4 >= 5'd6) begin
                tick_dig[4] = 4'd0;
                tick_dig[3] = v3[3:0];
                if (v3 >= 5'd10) begin
                    tick_dig[3] = 4'd0;
                    tick_dig[2] = v2[3:0];
                    if (v2 >= 5'd6) begin
                        tick_dig[2] = 4'd0;
                        tick_dig[1] = v1[3:0];
                        if (v1 >= 5'd10 && i_state.time_dig[0] < 4'd2) begin
                            tick_dig[1] = 4'd0;
                            tick_dig[0] = i_state.time_dig[0] + 4'd1;
                        end else if (i_state.time_dig[0] >= 4'd2 && v1 >= 5'd4) begin
                            tick_dig[0] = 4'd0;
                            tick_dig[1] = 4'd0;
                        end
                    end
                end
            end
        end
    end

    assign tick_inc  = {1'b0, i_state.tick_count} + 9'd1;
    assign sec_pulse = tick_inc >= {1'b0, i_ticks_per_second};
    assign is_digit  = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit_val = 4'(i_rx_byte - CH_ZERO);

    always_comb begin
        nxt   = i_state;
        ferr  = 1'b0;
        tdone = 1'b0;
        adone = 1'b0;
        if (i_operation == OP_TICK) begin
            if (i_state.running) begin
                if (sec_pulse) begin
                    nxt.tick_count = 8'd0;
                    nxt.time_dig   = tick_dig;
                end else begin
                    nxt.tick_count = tick_inc[7:0];
                end
            end
        end else begin
            priority if (!is_digit && i_rx_byte != CH_J && i_rx_byte != CH_N
                         && i_rx_byte != CH_E) begin
                ferr = 1'b1;
            end else if (i_rx_byte == CH_J) begin
                nxt.mode    = MODE_TIME;
                nxt.running = 1'b0;
            end else if (i_rx_byte == CH_N) begin
                nxt.mode = MODE_ALARM;
            end else if (i_rx_byte == CH_E) begin
                if (i_state.mode == MODE_TIME) begin
                    nxt.time_pos = 3'd0;
                    tdone        = 1'b1;
                end else if (i_state.mode == MODE_ALARM) begin
                    nxt.alarm_pos = 3'd0;
                    adone         = 1'b1;
                end
                nxt.mode    = MODE_IDLE;
                nxt.running = 1'b1;
            end else begin
                if (i_state.mode == MODE_TIME && i_state.time_pos < TIME_POS_MAX) begin
                    for (int i = 0; i < 6; i++) begin
                        if (i_state.time_pos == 3'(i)) begin
                            nxt.time_dig[i] = digit_val;
                        end
                    end
                    nxt.time_pos = i_state.time_pos + 3'd1;
                end else if (i_state.mode == MODE_ALARM
                             && i_state.alarm_pos < ALARM_POS_MAX) begin
                    for (int i = 0; i < 4; i++) begin
                        if (i_state.alarm_pos == 3'(i)) begin
                            nxt.alarm_dig[i] = digit_val;
                        end
                    end
                    nxt.alarm_pos = i_state.alarm_pos + 3'd1;
                end
            end
        end
    end

    assign alarm = (nxt.time_dig[0] == nxt.alarm_dig[0])
                && (nxt.time_dig[1] == nxt.alarm_dig[1])
                && (nxt.time_dig[2] == nxt.alarm_dig[2])
                && (nxt.time_dig[3] == nxt.alarm_dig[3]);

    assign o_state                 = nxt;
    assign o_result.time_dig       = nxt.time_dig;
    assign o_result.alarm_on       = alarm;
    assign o_result.format_error   = ferr;
    assign o_result.time_set_done  = tdone;
    assign o_result.alarm_set_done = adone;
    assign o_result.set_mode       = nxt.mode;

endmodule
